[sv/min_priority_queue_unit_macros.svh]
// Assertion macros for the priority queue unit.
// Each macro expects clk and rst_n in scope.
`ifndef MIN_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define MIN_PRIORITY_QUEUE_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent
`define MPQ_CHECK_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("priority queue check failed");

// Consequent checked in the cycle after the antecedent
`define MPQ_CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("priority queue check failed");

`endif

[sv/mpq_pkg.sv]
`timescale 1ns / 1ps

package mpq_pkg;

    localparam int CAPACITY = 16;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int OCC_W    = 5;
    localparam int STATUS_W = 2;

    // Commands
    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic                    cmd;
        logic signed [KEY_W-1:0] key;
    } mpq_req_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] removed_key;
        logic [STATUS_W-1:0]     status;
        logic [OCC_W-1:0]        occupancy;
    } mpq_rsp_t;

    // Operation broadcast to every cell
    typedef struct packed {
        logic                    enq;
        logic                    deq;
        logic signed [KEY_W-1:0] key;
    } mpq_op_t;

    // What a cell hands to its right neighbor
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic                    greater;
    } mpq_link_t;

endpackage

[sv/mpq_cell.sv]
`timescale 1ns / 1ps

module mpq_cell
    import mpq_pkg::*;
(
    input  logic                    clk,
    input  mpq_op_t                 op,
    input  logic                    occupied,
    input  mpq_link_t               left,
    input  logic signed [KEY_W-1:0] right_key,
    output mpq_link_t               link
);

    logic signed [KEY_W-1:0] key_reg;
    logic signed [KEY_W-1:0] key_next;
    logic                    greater;

    // An empty cell counts as greater, so the insert lands after all held keys
    assign greater = !occupied || (key_reg > op.key);

    always_comb
    begin
        key_next = key_reg;
        if (op.enq)
        begin
            priority if (greater && left.greater)
            begin
                key_next = left.key;
            end
            else if (greater)
            begin
                key_next = op.key;
            end
            else
            begin
                // key sorts before the new one: hold
                key_next = key_reg;
            end
        end
        else if (op.deq)
        begin
            key_next = right_key;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign link.key     = key_reg;
    assign link.greater = greater;

endmodule

[sv/min_priority_queue_unit.sv]
`timescale 1ns / 1ps
// Minimum priority queue of up to CAPACITY signed 32-bit keys, kept sorted.
// Request channel: req_valid / req_stall / req. cmd selects enqueue or
// dequeue of the smallest key; key is ignored on dequeue.
// Response channel: rsp_valid / rsp_stall / rsp. Each request gives one
// response with the removed key (zero unless a dequeue succeeded), a status
// (ok, empty on dequeue, full on enqueue) and the occupancy after it.
// Keys live in a row of cells; every cell compares its key with the new key
// at once and either holds, takes its left neighbor, takes the new key or
// takes its right neighbor.
// The response is registered and appears in the cycle after accept.
// One request is accepted per cycle while responses are taken.
// Equal keys leave in arrival order. A full enqueue drops the key.
// Reset empties the queue (count only; cell contents are not cleared) and
// drops any pending response. While rsp_stall holds a response, req_stall
// is raised and the queue state does not change.
`include "min_priority_queue_unit_macros.svh"

module min_priority_queue_unit
    import mpq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  mpq_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output mpq_rsp_t rsp
);

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               rsp_valid_reg;
    mpq_rsp_t           rsp_reg;
    mpq_rsp_t           rsp_next;

    logic               req_fire;
    logic               full;
    logic               empty;
    mpq_op_t            op;

    mpq_link_t               links [CAPACITY];
    logic [CAPACITY-1:0]     occupied;

    // Handshake: accept when the output register is free or being drained
    assign req_stall = rsp_valid_reg && rsp_stall;
    assign req_fire  = req_valid && !req_stall;

    assign full  = (count_reg == COUNT_W'(CAPACITY));
    assign empty = (count_reg == '0);

    assign op.enq = req_fire && (req.cmd == CMD_ENQ) && !full;
    assign op.deq = req_fire && (req.cmd == CMD_DEQ) && !empty;
    assign op.key = req.key;

    // Row of cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        mpq_link_t               left_in;
        logic signed [KEY_W-1:0] right_in;

        assign occupied[i] = (COUNT_W'(i) < count_reg);

        if (i == 0)
        begin : g_first
            assign left_in = '{key: '0, greater: 1'b0};
        end
        else
        begin : g_mid
            assign left_in = links[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_in = links[i].key;
        end
        else
        begin : g_inner
            assign right_in = links[i+1].key;
        end

        mpq_cell u_cell (
            .clk       (clk),
            .op        (op),
            .occupied  (occupied[i]),
            .left      (left_in),
            .right_key (right_in),
            .link      (links[i])
        );
    end

    // Count and response
    always_comb
    begin
        count_next = count_reg;
        rsp_next   = rsp_reg;
        if (req_fire)
        begin
            rsp_next.removed_key = '0;
            rsp_next.status      = ST_OK;
            unique case (req.cmd)
                CMD_ENQ:
                begin
                    if (full)
                    begin
                        rsp_next.status = ST_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + COUNT_W'(1);
                    end
                end
                CMD_DEQ:
                begin
                    if (empty)
                    begin
                        rsp_next.status = ST_EMPTY;
                    end
                    else
                    begin
                        rsp_next.removed_key = links[0].key;
                        count_next = count_reg - COUNT_W'(1);
                    end
                end
                default:
                begin
                    rsp_next.status = ST_OK;
                end
            endcase
            rsp_next.occupancy = OCC_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (req_fire)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Checks
    `MPQ_CHECK_NOW(a_count_bound, 1'b1, count_reg <= COUNT_W'(CAPACITY))
    `MPQ_CHECK_NEXT(a_fire_gives_rsp, req_fire, rsp_valid_reg)
    `MPQ_CHECK_NEXT(a_full_keeps_count, req_fire && req.cmd == CMD_ENQ && full, $stable(count_reg))
    `MPQ_CHECK_NOW(a_front_sorted, count_reg >= COUNT_W'(2), links[0].key <= links[1].key)

endmodule
